>>> rtl/core/gmw_pkg.sv
// Package for the gray median window filter: types, constants and helpers.
`default_nettype none
package gmw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int LINES      = 2 * MAX_RADIUS;
    localparam int WSIZE      = 2 * MAX_RADIUS + 1;
    localparam int WCELLS     = WSIZE * WSIZE;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int RAD_W      = 2;
    localparam int SLOT_W     = $clog2(LINES);
    localparam int RANK_W     = $clog2(WCELLS);
    localparam int CNT_W      = $clog2(WCELLS + 1);

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] median_value;
        logic       frame_done;
    } pix_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [RAD_W-1:0] window_radius;
    } cfg_t;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic       frame_done;
        logic       interior;
    } sel_meta_t;

    typedef logic [WCELLS-1:0][7:0] win_t;

    typedef struct packed {
        sel_meta_t         meta;
        logic [RANK_W-1:0] rank;
        logic [WCELLS-1:0] mask;
        logic [7:0]        prefix;
        win_t              vals;
    } sel_t;

    // cells of the 7x7 window that belong to a window of radius r
    function automatic logic [WCELLS-1:0] init_mask(input logic [RAD_W-1:0] r);
        logic [WCELLS-1:0] m;
        int                first;
        first = (WSIZE - 1) - 2 * int'(r);
        for (int i = 0; i < WSIZE; i++) begin
            for (int j = 0; j < WSIZE; j++) begin
                m[i*WSIZE+j] = (i >= first) && (j >= first);
            end
        end
        return m;
    endfunction

    // rank of the median, (2r+1)^2 / 2
    function automatic logic [RANK_W-1:0] init_rank(input logic [RAD_W-1:0] r);
        int n;
        n = (2 * int'(r) + 1) * (2 * int'(r) + 1);
        return RANK_W'(n / 2);
    endfunction

    // row modulo six by reciprocal multiply; exact for rows below 1024
    function automatic logic [SLOT_W-1:0] mod_lines(input logic [ROW_W-1:0] v);
        logic [ROW_W+10:0] p;
        logic [ROW_W-1:0]  q;
        logic [ROW_W-1:0]  rem;
        p   = (ROW_W+11)'(v) * (ROW_W+11)'(683);
        q   = ROW_W'(p >> 12);
        rem = v - ((q << 2) + (q << 1));
        return rem[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/gmw_line_window.sv
// Raster counters, gray conversion, line stores and the sliding 7x7 window.
`default_nettype none
module gmw_line_window (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire gmw_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gmw_pkg::pix_in_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gmw_pkg::sel_t      out_data
);
    import gmw_pkg::*;

    logic [CFG_W-1:0] wc, hc;
    logic [RAD_W-1:0] rc;
    logic [COL_W-1:0] cnt_col_reg, cnt_col_next;
    logic [ROW_W-1:0] cnt_row_reg, cnt_row_next;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [SLOT_W-1:0] slot;
    logic [9:0]        sum;
    logic [19:0]       prod;
    logic [7:0]        gray;
    logic              emit, last, interior;
    logic [CFG_W-1:0]  orow, ocol;
    logic              accept, s1_move;

    logic              v1_reg, emit1_reg;
    logic [7:0]        rd_reg [LINES];
    logic [7:0]        gray1_reg;
    logic [SLOT_W-1:0] slot1_reg;
    logic [RAD_W-1:0]  r1_reg;
    sel_meta_t         meta1_reg;

    logic              vw_reg;
    win_t              win_reg, win_next;
    sel_meta_t         metaw_reg;
    logic [RAD_W-1:0]  rw_reg;

    always_comb begin
        wc = cfg.image_width;
        if (wc < CFG_W'(WSIZE)) wc = CFG_W'(WSIZE);
        else if (wc > CFG_W'(MAX_WIDTH)) wc = CFG_W'(MAX_WIDTH);
        hc = cfg.image_height;
        if (hc < CFG_W'(WSIZE)) hc = CFG_W'(WSIZE);
        else if (hc > CFG_W'(MAX_HEIGHT)) hc = CFG_W'(MAX_HEIGHT);
        rc = (cfg.window_radius == '0) ? RAD_W'(1) : cfg.window_radius;

        col = ({1'b0, cnt_col_reg} < wc) ? cnt_col_reg : COL_W'(wc - 1'b1);
        row = ({1'b0, cnt_row_reg} < hc) ? cnt_row_reg : ROW_W'(hc - 1'b1);
        slot = mod_lines(row);

        sum  = 10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue);
        prod = 20'(sum) * 20'(683);
        gray = prod[18:11];

        last = ({1'b0, row} == hc - 1'b1) && ({1'b0, col} == wc - 1'b1);
        emit = (row > ROW_W'(rc)) || ((row == ROW_W'(rc)) && (col >= COL_W'(rc)));
        if (col >= COL_W'(rc)) begin
            orow = CFG_W'(row) - CFG_W'(rc);
            ocol = CFG_W'(col) - CFG_W'(rc);
        end else begin
            orow = CFG_W'(row) - CFG_W'(rc) - 1'b1;
            ocol = CFG_W'(col) + wc - CFG_W'(rc);
        end
        interior = (orow >= CFG_W'(rc)) && (orow < hc - CFG_W'(rc)) &&
                   (ocol >= CFG_W'(rc)) && (ocol < wc - CFG_W'(rc));

        if ({1'b0, col} >= wc - 1'b1) begin
            cnt_col_next = '0;
            cnt_row_next = ({1'b0, row} >= hc - 1'b1) ? '0 : row + 1'b1;
        end else begin
            cnt_col_next = col + 1'b1;
            cnt_row_next = row;
        end
    end

    assign in_ready = !v1_reg || s1_move;
    assign accept   = in_valid && in_ready;
    // the window advances for every pixel; only emitting ones enter selection
    assign s1_move  = v1_reg && (!vw_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_col_reg <= '0;
            cnt_row_reg <= '0;
            v1_reg      <= 1'b0;
        end else begin
            if (accept) begin
                cnt_col_reg <= cnt_col_next;
                cnt_row_reg <= cnt_row_next;
                v1_reg      <= 1'b1;
            end else if (s1_move) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gray1_reg          <= gray;
            slot1_reg          <= slot;
            r1_reg             <= rc;
            emit1_reg          <= emit;
            meta1_reg.out_row  <= orow[9:0];
            meta1_reg.out_col  <= ocol[9:0];
            meta1_reg.frame_done <= last;
            meta1_reg.interior <= interior;
        end
    end

    // one store per line slot: read the old entry and write the new one
    for (genvar k = 0; k < LINES; k++) begin : g_line
        logic [7:0] mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (accept) begin
                rd_reg[k] <= mem[col];
                if (slot == SLOT_W'(k)) begin
                    mem[col] <= gray;
                end
            end
        end
    end

    always_comb begin
        logic [SLOT_W:0] s;
        for (int i = 0; i < WSIZE; i++) begin
            for (int j = 0; j < WSIZE - 1; j++) begin
                win_next[i*WSIZE+j] = win_reg[i*WSIZE+j+1];
            end
        end
        for (int i = 0; i < LINES; i++) begin
            s = (SLOT_W+1)'(slot1_reg) + (SLOT_W+1)'(i);
            if (s >= (SLOT_W+1)'(LINES)) s = s - (SLOT_W+1)'(LINES);
            win_next[i*WSIZE+WSIZE-1] = rd_reg[s[SLOT_W-1:0]];
        end
        win_next[WCELLS-1] = gray1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg  <= 1'b0;
            win_reg <= '0;
        end else begin
            if (s1_move) begin
                vw_reg  <= emit1_reg;
                win_reg <= win_next;
            end else if (out_ready) begin
                vw_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            metaw_reg <= meta1_reg;
            rw_reg    <= r1_reg;
        end
    end

    assign out_valid       = vw_reg;
    assign out_data.meta   = metaw_reg;
    assign out_data.rank   = init_rank(rw_reg);
    assign out_data.mask   = init_mask(rw_reg);
    assign out_data.prefix = '0;
    assign out_data.vals   = win_reg;

endmodule
`default_nettype wire

>>> rtl/core/gmw_bit_stage.sv
// One bit of the radix median selection, with its pipeline register.
`default_nettype none
module gmw_bit_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [2:0]    bit_sel,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gmw_pkg::sel_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gmw_pkg::sel_t      out_data
);
    import gmw_pkg::*;

    logic              v_reg;
    sel_t              data_reg, data_next;
    logic [WCELLS-1:0] plane;
    logic [CNT_W-1:0]  zeros;

    always_comb begin
        for (int j = 0; j < WCELLS; j++) begin
            plane[j] = in_data.vals[j][bit_sel];
        end
        zeros = '0;
        for (int j = 0; j < WCELLS; j++) begin
            zeros = zeros + CNT_W'(in_data.mask[j] & ~plane[j]);
        end
        data_next = in_data;
        if (CNT_W'(in_data.rank) < zeros) begin
            data_next.mask            = in_data.mask & ~plane;
            data_next.prefix[bit_sel] = 1'b0;
        end else begin
            data_next.mask            = in_data.mask & plane;
            data_next.rank            = in_data.rank - RANK_W'(zeros);
            data_next.prefix[bit_sel] = 1'b1;
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> rtl/core/gray_median_window_filter.sv
// Top level of the gray median window filter: register port and pipeline.
`default_nettype none
// Channel   Ports                         Transaction
// input     s_valid s_ready s_pixel       one RGB pixel, raster order
// output    m_valid m_ready m_result      row, column, median, frame end
// config    psel penable pwrite paddr ... width, height, radius at 0, 4, 8
//
// One pixel is taken every cycle while the output is not stalled; the line stores
// are one read and one write port per line slot, so the window can advance each
// cycle. A result passes the line read, the window shift, then one stage per gray
// bit of the median selection. Reset clears counters, window and pipeline valid
// bits; line store contents stay undefined until written.
// A stalled output holds each stage in turn; bubbles still move forward.
module gray_median_window_filter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire gmw_pkg::pix_in_t  s_pixel,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output gmw_pkg::pix_out_t      m_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import gmw_pkg::*;

    localparam int NSTG = 8;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       stg_valid [NSTG+1];
    logic       stg_ready [NSTG+1];
    sel_t       stg_data  [NSTG+1];

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[3:2]);

    // write a register on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= CFG_W'(MAX_WIDTH);
            cfg_reg.image_height  <= CFG_W'(MAX_HEIGHT);
            cfg_reg.window_radius <= RAD_W'(1);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[CFG_W-1:0];
                REG_WINDOW_RADIUS: cfg_reg.window_radius <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_IMAGE_WIDTH:   prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:  prdata = 32'(cfg_reg.image_height);
            REG_WINDOW_RADIUS: prdata = 32'(cfg_reg.window_radius);
            default:           prdata = '0;
        endcase
    end

    // convert, store lines and slide the window
    gmw_line_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_pixel),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // resolve the median one bit per stage, most significant first
    for (genvar n = 0; n < NSTG; n++) begin : g_sel
        gmw_bit_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .bit_sel   (3'(NSTG - 1 - n)),
            .in_valid  (stg_valid[n]),
            .in_ready  (stg_ready[n]),
            .in_data   (stg_data[n]),
            .out_valid (stg_valid[n+1]),
            .out_ready (stg_ready[n+1]),
            .out_data  (stg_data[n+1])
        );
    end

    assign stg_ready[NSTG] = m_ready;
    assign m_valid         = stg_valid[NSTG];

    // drop the median for border pixels
    assign m_result.out_row      = stg_data[NSTG].meta.out_row;
    assign m_result.out_col      = stg_data[NSTG].meta.out_col;
    assign m_result.frame_done   = stg_data[NSTG].meta.frame_done;
    assign m_result.median_value = stg_data[NSTG].meta.interior ?
                                   stg_data[NSTG].prefix : 8'd0;

endmodule
`default_nettype wire

>>> bench/gray_median_window_filter_test.sv
// Testbench for the gray median window filter: random frames checked against a predictor.
module gray_median_window_filter_test;
    import gmw_pkg::*;

    localparam int LAT_WAIT   = 24;    // ten-stage pipeline plus margin
    localparam int WDOG_LIMIT = 4000;  // idle cycles allowed: long hold-off plus stalls
    localparam int HOLD_LEN   = 400;   // receiver hold-off, long enough to back up the pipe

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    pix_in_t     s_pixel = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    pix_out_t    m_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gray_median_window_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Pixels waiting to be offered, and results the filter still owes us.
    pix_in_t  pending_pixels[$];
    pix_out_t expected_results[$];
    int       error_count = 0;

    // Knobs set by the sequence: idling on either side, and the long hold-off.
    logic     tx_idle = 1'b0;
    logic     rx_idle = 1'b0;
    int       hold_req = 0;

    // Predictor state: register copies, line stores, window and raster position.
    logic [CFG_W-1:0] cfg_width  = 11'd1024;
    logic [CFG_W-1:0] cfg_height = 11'd1024;
    logic [RAD_W-1:0] cfg_radius = 2'd1;
    logic [7:0]       gray_lines[LINES*MAX_WIDTH];
    logic [7:0]       win_pix[WSIZE][WSIZE];
    int               cur_col = 0;
    int               cur_row = 0;

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int eff_width();
        return clamp_int(int'(cfg_width), WSIZE, MAX_WIDTH);
    endfunction

    function automatic int eff_height();
        return clamp_int(int'(cfg_height), WSIZE, MAX_HEIGHT);
    endfunction

    function automatic int eff_radius();
        return clamp_int(int'(cfg_radius), 1, MAX_RADIUS);
    endfunction

    // Median of the (2r+1)^2 cells in the bottom-right corner of the window.
    function automatic logic [7:0] window_median(int r);
        logic [7:0] sorted[WCELLS];
        logic [7:0] v;
        int         n;
        int         k;
        int         first;
        n = 0;
        first = (WSIZE - 1) - 2 * r;
        for (int i = first; i < WSIZE; i++) begin
            for (int j = first; j < WSIZE; j++) begin
                v = win_pix[i][j];
                k = n;
                while (k > 0 && sorted[k-1] > v) begin
                    sorted[k] = sorted[k-1];
                    k--;
                end
                sorted[k] = v;
                n++;
            end
        end
        return sorted[n/2];
    endfunction

    // Advance the predictor by one accepted pixel; queue the result it triggers.
    task automatic predict_median(input pix_in_t px);
        int         w;
        int         h;
        int         r;
        int         col;
        int         row;
        int         slot;
        int         orow;
        int         ocol;
        logic [7:0] gray;
        logic [7:0] med;
        pix_out_t   res;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        col = (cur_col < w) ? cur_col : w - 1;
        row = (cur_row < h) ? cur_row : h - 1;
        gray = 8'((int'(px.red) + int'(px.green) + int'(px.blue)) / 3);
        slot = row % LINES;
        med = '0;
        // shift the window left, pull in the new column from the line stores
        for (int i = 0; i < WSIZE; i++)
            for (int j = 0; j < WSIZE - 1; j++)
                win_pix[i][j] = win_pix[i][j+1];
        for (int i = 0; i < LINES; i++)
            win_pix[i][WSIZE-1] = gray_lines[((slot + i) % LINES) * MAX_WIDTH + col];
        win_pix[WSIZE-1][WSIZE-1] = gray;
        gray_lines[slot * MAX_WIDTH + col] = gray;
        if (row > r || (row == r && col >= r)) begin
            if (col >= r) begin
                orow = row - r;
                ocol = col - r;
            end else begin
                orow = row - r - 1;
                ocol = col + w - r;
            end
            if (orow >= r && orow < h - r && ocol >= r && ocol < w - r)
                med = window_median(r);
            res.out_row      = 10'(orow);
            res.out_col      = 10'(ocol);
            res.median_value = med;
            res.frame_done   = (row == h - 1) && (col == w - 1);
            expected_results.push_back(res);
        end
        if (col >= w - 1) begin
            cur_col = 0;
            cur_row = (row >= h - 1) ? 0 : row + 1;
        end else begin
            cur_col = col + 1;
            cur_row = row;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Driver: offer the next pixel once the gap drawn for it has run out.
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                predict_median(s_pixel);
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                s_valid <= 1'b1;
                s_pixel <= pending_pixels.pop_front();
                tx_gap = tx_idle ? $urandom_range(0, 10) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction, then draw the next stall.
    int rx_stall = 0;
    int hold_left = 0;
    int hold_ack = 0;
    always @(posedge aclk) begin
        pix_out_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result row %0d col %0d",
                                              m_result.out_row, m_result.out_col));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_result.out_row !== exp_res.out_row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  m_result.out_row, exp_res.out_row));
                    if (m_result.out_col !== exp_res.out_col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  m_result.out_col, exp_res.out_col));
                    if (m_result.median_value !== exp_res.median_value)
                        report_mismatch($sformatf("median %0d, want %0d at (%0d,%0d)",
                                                  m_result.median_value,
                                                  exp_res.median_value,
                                                  exp_res.out_row, exp_res.out_col));
                    if (m_result.frame_done !== exp_res.frame_done)
                        report_mismatch($sformatf("frame_done %0b, want %0b at (%0d,%0d)",
                                                  m_result.frame_done, exp_res.frame_done,
                                                  exp_res.out_row, exp_res.out_col));
                end
                rx_stall = rx_idle ? $urandom_range(0, 10) : 0;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                hold_left = HOLD_LEN;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_ready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle; the predictor follows.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = value[CFG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = value[CFG_W-1:0];
            end
            REG_WINDOW_RADIUS: begin
                cfg_radius = value[RAD_W-1:0];
            end
            default: ;
        endcase
    endtask

    // Hold until every pixel is taken and every result is back, then let the pipe drain.
    task automatic drain();
        do @(negedge aclk);
        while (pending_pixels.size() > 0 || s_valid || expected_results.size() > 0);
        repeat (LAT_WAIT) @(negedge aclk);
    endtask

    function automatic pix_in_t random_pixel();
        pix_in_t px;
        px.red   = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue  = 8'($urandom_range(0, 255));
        return px;
    endfunction

    // Program a frame size and radius, then queue whole frames of random pixels.
    task automatic queue_frames(input int w, input int h, input int r, input int frames);
        int n;
        write_reg(REG_IMAGE_WIDTH, 32'(w));
        write_reg(REG_IMAGE_HEIGHT, 32'(h));
        write_reg(REG_WINDOW_RADIUS, 32'(r));
        n = frames * eff_width() * eff_height();
        for (int i = 0; i < n; i++)
            pending_pixels.push_back(random_pixel());
    endtask

    initial begin
        pix_in_t px;
        int      sent;
        int      w;
        int      h;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: smallest frame, radius 1, field extremes and gray rounding first.
        write_reg(REG_IMAGE_WIDTH, 32'd7);
        write_reg(REG_IMAGE_HEIGHT, 32'd7);
        write_reg(REG_WINDOW_RADIUS, 32'd1);
        for (int i = 0; i < 49; i++) begin
            case (i % 8)
                0: px = '{8'd0, 8'd0, 8'd0};
                1: px = '{8'd255, 8'd255, 8'd255};
                2: px = '{8'd255, 8'd0, 8'd0};
                3: px = '{8'd0, 8'd255, 8'd0};
                4: px = '{8'd0, 8'd0, 8'd255};
                5: px = '{8'd1, 8'd1, 8'd0};
                6: px = '{8'd170, 8'd85, 8'd254};
                default: px = random_pixel();
            endcase
            pending_pixels.push_back(px);
        end
        drain();

        // Out-of-range settings: zero radius acts as 1, small sizes saturate up.
        queue_frames(0, 3, 0, 1);
        drain();
        queue_frames(7, 7, 3, 2);
        drain();

        // Oversized width saturates to the largest; stop part way into the second
        // row so the next size change lands mid-frame.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 32'd2047);
        write_reg(REG_IMAGE_HEIGHT, 32'd7);
        write_reg(REG_WINDOW_RADIUS, 32'd1);
        for (int i = 0; i < 1100; i++)
            pending_pixels.push_back(random_pixel());
        drain();

        // Back-pressure: the receiver holds off while the sender keeps offering.
        tx_idle = 1'b0;
        hold_req <= hold_req + 1;
        queue_frames(12, 9, 2, 2);
        drain();

        // Random frames, small sizes; idling toggled per phase.
        sent = 0;
        while (sent < 240) begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 6) : $urandom_range(7, 20);
            h = $urandom_range(7, 12);
            queue_frames(w, h, $urandom_range(0, 3), $urandom_range(1, 2));
            sent += pending_pixels.size();
            drain();
        end

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gmw_pkg.sv
rtl/core/gmw_line_window.sv
rtl/core/gmw_bit_stage.sv
rtl/core/gray_median_window_filter.sv
bench/gray_median_window_filter_test.sv
